// File: hw/rtl/cross_entropy_loss_and_gradient_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cross-entropy loss and gradient block
// Shared macros for concurrent assertions clocked on clk with sync reset.
// ----------------------------------------------------------------------------
`ifndef CROSS_ENTROPY_LOSS_AND_GRADIENT_MACROS_SVH
`define CROSS_ENTROPY_LOSS_AND_GRADIENT_MACROS_SVH

// Implication checked every clock edge while out of reset.
`define CEL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define CEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cel_pkg.sv
// ----------------------------------------------------------------------------
// Cross-entropy package
// Types, constants and the log table shared by the cross-entropy modules.
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_CLASSES = 1024;
  localparam int CNT_W       = $clog2(MAX_CLASSES + 1);

  localparam logic [16:0] ONE_FX     = 17'd65536;
  localparam logic [24:0] GRAD_LIMIT = 25'd16777216;
  localparam logic [19:0] LOSS_MAX   = 20'hFFFFF;
  localparam logic [31:0] LN2_Q30    = 32'd744261118;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BATCH = 2'd0;
  localparam logic [1:0] REG_NCLS  = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  typedef struct packed {
    logic [16:0] prob;
    logic [9:0]  label;
  } cel_in_t;

  typedef struct packed {
    logic signed [25:0] grad;
    logic [19:0]        loss;
    logic               loss_valid;
    logic               last;
    logic               label_error;
  } cel_out_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;      // capture input item, compute gradient product
    logic finish;    // produce result, update running sums
    logic log_step;  // one normalization step of the log
    logic div_start; // start divider
    logic div_step;  // one divider step
  } cel_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic need_log;  // label column with p below one
    logic end_batch;
    logic log_done;
    logic div_done;
  } cel_stat_t;

  // ln(1 + 2^-k) in Q30, k = 1..30.
  function automatic logic [31:0] ln1p_pow2(input logic [4:0] k);
    logic [31:0] v;
    begin
      case (k)
        5'd1: v = 32'd435364845;
        5'd2: v = 32'd239598564;
        5'd3: v = 32'd126468572;
        5'd4: v = 32'd65095192;
        5'd5: v = 32'd33040817;
        5'd6: v = 32'd16647493;
        5'd7: v = 32'd8356010;
        5'd8: v = 32'd4186133;
        default: v = (32'd1 << (30 - k)) - ((k >= 5'd15) ? 32'd0 : (32'd1 << (29 - 2 * k)));
      endcase
      return v;
    end
  endfunction

endpackage

// File: hw/rtl/cel_ctrl.sv
// ----------------------------------------------------------------------------
// Cross-entropy controller
// Sequences load, log iterations, batch-mean division and result issue.
// ----------------------------------------------------------------------------
module cel_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_busy,
  input  cel_pkg::cel_stat_t stat,
  output cel_pkg::cel_cmd_t  cmd
);
  import cel_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_LOG, S_DIV, S_DONE} state_t;

  state_t state_r, state_nxt;

  // Accept only while idle; the result register gets a free slot first.
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.need_log) begin
          state_nxt = S_LOG;
        end else if (stat.end_batch) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        if (stat.log_done) begin
          if (stat.end_batch) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/cel_dp.sv
// ----------------------------------------------------------------------------
// Cross-entropy datapath
// Gradient product, iterative log, loss sum, serial divider and counters.
// ----------------------------------------------------------------------------
module cel_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cel_pkg::cel_in_t   in_data,
  input  cel_pkg::cel_cmd_t  cmd,
  output cel_pkg::cel_stat_t stat,
  input  logic [15:0]        batch_size,
  input  logic [10:0]        num_classes,
  input  logic [31:0]        gradient_scale,
  output cel_pkg::cel_out_t  res
);
  import cel_pkg::*;
  `include "cross_entropy_loss_and_gradient_macros.svh"

  logic [16:0] prob_r;
  logic        hit_r, err_r, end_row_r, end_batch_r;
  logic [24:0] mag_r;
  logic [47:0] prod_r;
  logic [9:0]  col_r;
  logic [15:0] row_r;
  logic [31:0] sum_r;
  logic [31:0] y_r;
  logic [35:0] acc_r;
  logic [4:0]  k_r;
  logic        log_act_r;
  logic [31:0] sum_in_r;
  logic [31:0] quo_r;
  logic [16:0] rem_r;
  logic [5:0]  dcnt_r;

  logic [16:0] p_cl;
  logic [10:0] nc;
  logic [16:0] rows;
  logic        err, hit;
  logic [4:0]  msb;
  logic [32:0] y_try;

  // Effective class count and row count, clamped probability, label error and hit.
  always_comb begin
    nc = num_classes;
    if (num_classes == 11'd0) nc = 11'd1;
    else if (num_classes > 11'(MAX_CLASSES)) nc = 11'(MAX_CLASSES);
    rows = (batch_size == 16'd0) ? 17'd1 : {1'b0, batch_size};
    p_cl = (in_data.prob > ONE_FX) ? ONE_FX : in_data.prob;
    err  = {1'b0, in_data.label} >= nc;
    hit  = !err && (col_r == in_data.label);
  end

  // Leading-one position of the clamped probability, 16 at most.
  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (prob_r[i]) msb = 5'(i);
    end
  end

  assign y_try = {1'b0, y_r} + {1'b0, (y_r >> k_r)};

  // Capture the item, the gradient magnitude and the end-of-row and end-of-batch flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prob_r      <= (p_cl == 17'd0) ? 17'd1 : p_cl;
      hit_r       <= hit;
      err_r       <= err;
      mag_r       <= 25'(hit ? (ONE_FX - p_cl) : p_cl);
      end_row_r   <= ({1'b0, col_r} + 11'd1) >= nc;
      end_batch_r <= (({1'b0, col_r} + 11'd1) >= nc) && (({1'b0, row_r} + 17'd1) >= rows);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 48'(mag_r[16:0] * gradient_scale);
  end

  // Normalize-and-accumulate log, one k per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_act_r <= 1'b0;
    end else if (cmd.load) begin
      log_act_r <= 1'b0;
    end else if (cmd.log_step) begin
      if (!log_act_r) begin
        log_act_r <= 1'b1;
        y_r   <= 32'({15'd0, prob_r} << (5'd30 - msb));
        acc_r <= 36'((5'd15 - msb) * LN2_Q30);
        k_r   <= 5'd1;
      end else begin
        if (y_try < 33'h80000000) begin
          y_r   <= y_try[31:0];
          acc_r <= acc_r + 36'(ln1p_pow2(k_r));
        end
        k_r <= k_r + 5'd1;
      end
    end
  end

  logic [36:0] nl_full;
  logic [32:0] sum_add;
  assign nl_full = ({1'b0, acc_r} + 37'd8192) >> 14;
  assign sum_add = {1'b0, sum_r} + 33'(nl_full);
  assign stat.need_log  = hit_r && (prob_r < ONE_FX);
  assign stat.end_batch = end_batch_r;
  assign stat.log_done  = log_act_r && (k_r == 5'd30) && !(y_try < 33'h80000000 && 1'b0);
  assign stat.div_done  = (dcnt_r == 6'd0);

  logic [31:0] sum_eff;
  always_comb begin
    sum_eff = sum_r;
    if (stat.need_log && log_act_r) sum_eff = sum_add[32] ? 32'hFFFFFFFF : sum_add[31:0];
  end

  // Restoring divider, one quotient bit per cycle.
  logic [17:0] rtry;
  assign rtry = {rem_r, sum_in_r[31]} - {1'b0, rows};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= 6'd0;
    end else if (cmd.div_start || (cmd.log_step && stat.log_done && end_batch_r)) begin
      dcnt_r   <= 6'd33;
      sum_in_r <= 32'd0;
      quo_r    <= 32'd0;
      rem_r    <= 17'd0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 6'd1;
      if (dcnt_r == 6'd33) begin
        sum_in_r <= sum_eff;
      end else begin
        sum_in_r <= sum_in_r << 1;
        if (!rtry[17]) begin
          rem_r <= rtry[16:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[15:0], sum_in_r[31]};
          quo_r <= {quo_r[30:0], 1'b0};
        end
      end
    end
  end

  // Result and state update.
  logic [24:0] r_rnd;
  logic [32:0] q_rnd;
  always_comb begin
    r_rnd = 25'((prod_r + 48'd32768) >> 16);
    if (((prod_r + 48'd32768) >> 16) > 48'(GRAD_LIMIT)) r_rnd = GRAD_LIMIT;
    q_rnd = {1'b0, quo_r} + (({rem_r, 1'b0} >= {1'b0, rows}) ? 33'd1 : 33'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      sum_r <= '0;
    end else if (cmd.finish) begin
      res.grad        <= hit_r ? -$signed({1'b0, r_rnd}) : $signed({1'b0, r_rnd});
      res.loss_valid  <= end_batch_r;
      res.last        <= end_batch_r;
      res.label_error <= err_r;
      res.loss        <= !end_batch_r ? 20'd0 :
                         (q_rnd > 33'(LOSS_MAX)) ? LOSS_MAX : q_rnd[19:0];
      if (end_batch_r) begin
        col_r <= '0;
        row_r <= '0;
        sum_r <= '0;
      end else begin
        sum_r <= sum_eff;
        if (end_row_r) begin
          col_r <= '0;
          row_r <= row_r + 16'd1;
        end else begin
          col_r <= col_r + 10'd1;
        end
      end
    end
  end

  `CEL_ASSERT_IMP(a_log_sel, cmd.log_step, stat.need_log, "log step without label hit")
  `CEL_ASSERT_IMP(a_err_nohit, err_r && cmd.finish, !hit_r, "error item marked as hit")
  `CEL_ASSERT_IMP(a_one_cmd, cmd.load, !cmd.finish, "load and finish together")

endmodule

// File: hw/rtl/cross_entropy_loss_and_gradient.sv
// ----------------------------------------------------------------------------
// Cross-entropy loss and gradient
// Per-element gradient of softmax cross entropy with streamed batch mean loss.
// ----------------------------------------------------------------------------
// An element not at its row's label column, or with probability one, passes
// through the idle, evaluate and done states. A label element below one also
// runs the serial log unit, and the batch's last element the serial mean
// divider. One element is computed at a time, and the next one may be
// accepted while the previous result still waits in the output register.
// After a register write the input stalls while the gradient scale is
// recomputed by a serial divider.
module cross_entropy_loss_and_gradient (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cel_pkg::cel_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cel_pkg::cel_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import cel_pkg::*;

  cel_cmd_t  cmd;
  cel_stat_t stat;
  logic [15:0] batch_r;
  logic [10:0] ncls_r;
  logic [23:0] scale_r;
  logic [31:0] gscale_r;
  logic        out_valid_r;
  logic        recalc_r;
  logic [16:0] div;
  logic [1:0]  ridx;
  logic        cfg_busy;
  logic        ctrl_stall;

  assign pready = 1'b1;
  assign ridx   = paddr[3:2];
  assign div    = (batch_r == 16'd0) ? 17'd1 : {1'b0, batch_r};

  // Register writes; the scale divide runs serially afterwards.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r  <= 16'd1;
      ncls_r   <= 11'd10;
      scale_r  <= 24'd65536;
      recalc_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      recalc_r <= 1'b1;
      unique case (ridx)
        REG_BATCH: batch_r <= pwdata[15:0];
        REG_NCLS:  ncls_r  <= pwdata[10:0];
        REG_SCALE: scale_r <= pwdata[23:0];
        default: recalc_r <= 1'b0;
      endcase
    end else begin
      recalc_r <= 1'b0;
    end
  end

  // Serial divider for the gradient scale, one bit per cycle.
  logic [5:0]  sc_r;
  logic [24:0] sn_r;
  logic [17:0] srem_r;
  logic [24:0] squo_r;
  logic [18:0] strial;
  assign strial = {srem_r, sn_r[24]} - {2'b0, div};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r     <= 6'd0;
      gscale_r <= 32'd65536;
    end else if (recalc_r) begin
      sc_r   <= 6'd25;
      sn_r   <= 25'(scale_r) + 25'(div >> 1);
      srem_r <= '0;
      squo_r <= '0;
    end else if (sc_r != 6'd0) begin
      sc_r <= sc_r - 6'd1;
      sn_r <= sn_r << 1;
      if (!strial[18]) begin
        srem_r <= strial[17:0];
        squo_r <= {squo_r[23:0], 1'b1};
        if (sc_r == 6'd1) gscale_r <= 32'({squo_r[23:0], 1'b1});
      end else begin
        srem_r <= {srem_r[16:0], sn_r[24]};
        squo_r <= {squo_r[23:0], 1'b0};
        if (sc_r == 6'd1) gscale_r <= 32'({squo_r[23:0], 1'b0});
      end
    end
  end

  // Hold off new transactions until the gradient scale is up to date.
  assign cfg_busy = recalc_r || (sc_r != 6'd0);
  assign in_stall = ctrl_stall || cfg_busy;

  always_comb begin
    unique case (ridx)
      REG_BATCH: prdata = {16'd0, batch_r};
      REG_NCLS:  prdata = {21'd0, ncls_r};
      REG_SCALE: prdata = {8'd0, scale_r};
      default:   prdata = 32'd0;
    endcase
  end

  cel_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid && !cfg_busy), .in_stall(ctrl_stall),
    .out_busy(out_valid_r && out_stall), .stat(stat), .cmd(cmd)
  );

  cel_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
    .batch_size(batch_r), .num_classes(ncls_r), .gradient_scale(gscale_r),
    .res(out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end
  assign out_valid = out_valid_r;

endmodule
